// ===== design/mbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and helpers for the Mandelbrot membership test
// Fixed-point formats, the point record that moves through the request queue,
// the engine state encoding and the input conversion function.
// ----------------------------------------------------------------------------
package mbt_pkg;

	// Internal fixed point: FRAC_BITS fraction bits, FRAC_BITS+8 bits in total.
	localparam int FRAC_BITS  = 28;
	localparam int IN_W       = 32;
	localparam int IN_FRAC    = 28;
	localparam int Z_W        = FRAC_BITS + 8;
	// Magnitude of a z component known to be below 2.
	localparam int MAG_W      = FRAC_BITS + 1;
	// Truncated product of two such magnitudes, below 4.
	localparam int SQ_W       = FRAC_BITS + 2;
	localparam int UP_SHIFT   = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
	localparam int DOWN_SHIFT = (FRAC_BITS < IN_FRAC) ? (IN_FRAC - FRAC_BITS) : 0;
	localparam int CVT_W      = IN_W + UP_SHIFT;
	localparam int ITER_W     = 16;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef logic signed [Z_W-1:0]    z_t;
	typedef logic        [MAG_W-1:0]  mag_t;
	typedef logic        [SQ_W-1:0]   sq_t;
	typedef logic        [ITER_W-1:0] iter_t;

	typedef struct packed {
		z_t cr;
		z_t ci;
	} point_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_ADD,
		ENG_MUL
	} eng_state_t;

	localparam iter_t         MAX_ITER_RESET = ITER_W'(10000);
	localparam z_t            TWO            = Z_W'(64'sd1 <<< (FRAC_BITS + 1));
	localparam logic [SQ_W:0] FOUR           = (SQ_W + 1)'(64'd1 << (FRAC_BITS + 2));

	// Q3.28 input to the internal format. Dropped fraction bits round toward
	// minus infinity, which is what an arithmetic right shift does.
	function automatic z_t load_c(input logic signed [IN_W-1:0] raw);
		logic signed [CVT_W-1:0] wide;
		wide = CVT_W'(raw);
		wide = wide <<< UP_SHIFT;
		wide = wide >>> DOWN_SHIFT;
		return Z_W'(wide);
	endfunction

	// Absolute value of a component, kept to the bits a value below 2 needs.
	function automatic mag_t magnitude(input z_t v);
		z_t a;
		a = v[Z_W-1] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

endpackage

// ===== design/mbt_front.sv =====
// ----------------------------------------------------------------------------
// mbt_front: request intake
// Accepts points, converts them to the internal fixed-point format in one
// register stage and pushes them into the request queue.
// ----------------------------------------------------------------------------
module mbt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   c_real,
	input  logic signed [31:0]   c_imag,
	output logic                 push,
	output mbt_pkg::point_t      push_data,
	input  logic                 q_full
);

	logic            v_s1;
	mbt_pkg::point_t pt_s1;

	assign in_ready  = !v_s1 || !q_full;
	assign push      = v_s1 && !q_full;
	assign push_data = pt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pt_s1.cr <= mbt_pkg::load_c(c_real);
			pt_s1.ci <= mbt_pkg::load_c(c_imag);
		end
	end

endmodule

// ===== design/mbt_queue.sv =====
// ----------------------------------------------------------------------------
// mbt_queue: short request queue
// Small FIFO between the intake and the iteration engine so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module mbt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mbt_pkg::point_t      push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output mbt_pkg::point_t      pop_data
);

	mbt_pkg::point_t                    mem [mbt_pkg::QDEPTH];
	logic [mbt_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [mbt_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [mbt_pkg::QCNT_W-1:0]         cnt_q;

	localparam logic [mbt_pkg::QPTR_W-1:0] LAST = mbt_pkg::QPTR_W'(mbt_pkg::QDEPTH - 1);

	assign full      = (cnt_q == mbt_pkg::QCNT_W'(mbt_pkg::QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + mbt_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + mbt_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + mbt_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - mbt_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/mbt_engine.sv =====
// ----------------------------------------------------------------------------
// mbt_engine: escape-time iteration engine
// Runs z = z*z + c with an add state and a multiply state per iteration, and
// holds the verdict in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mbt_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbt_pkg::iter_t       max_iterations,
	input  logic                 q_valid,
	input  mbt_pkg::point_t      q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 in_set
);

	mbt_pkg::eng_state_t state_q, state_d;

	mbt_pkg::z_t    cr_q, ci_q, zr_q, zi_q, ri_q;
	mbt_pkg::sq_t   rr_q, ii_q;
	logic           big_q;
	mbt_pkg::iter_t iter_q;
	logic           out_valid_q;
	logic           in_set_q;

	logic [mbt_pkg::SQ_W:0]       sum;
	logic                         escaped, finish, out_free;
	mbt_pkg::z_t                  zr_next, zi_next;
	logic                         big_next;
	mbt_pkg::mag_t                mr, mi;
	logic [2*mbt_pkg::MAG_W-1:0]  prr, pii, pri;
	mbt_pkg::sq_t                 ri_mag;
	mbt_pkg::z_t                  ri_val;
	logic                         load, do_step, do_mul, deliver;

	// Escape test on the last update: a component out of range, or the
	// truncated squares (computed in the multiply cycle) summing to 4 or more.
	assign sum      = {1'b0, rr_q} + {1'b0, ii_q};
	assign escaped  = big_q || (sum >= mbt_pkg::FOUR);
	assign finish   = escaped || (iter_q == max_iterations);
	assign out_free = !out_valid_q || out_ready;

	assign zr_next  = $signed(mbt_pkg::Z_W'(rr_q)) - $signed(mbt_pkg::Z_W'(ii_q)) + cr_q;
	assign zi_next  = (ri_q <<< 1) + ci_q;
	assign big_next = (zr_next >= mbt_pkg::TWO) || (zr_next <= -mbt_pkg::TWO) ||
	                  (zi_next >= mbt_pkg::TWO) || (zi_next <= -mbt_pkg::TWO);

	// Products of the new z. Operands are only meaningful when both parts
	// are below 2; otherwise big_q already decides the escape.
	assign mr     = mbt_pkg::magnitude(zr_q);
	assign mi     = mbt_pkg::magnitude(zi_q);
	assign prr    = mr * mr;
	assign pii    = mi * mi;
	assign pri    = mr * mi;
	assign ri_mag = pri[mbt_pkg::FRAC_BITS +: mbt_pkg::SQ_W];
	assign ri_val = (zr_q[mbt_pkg::Z_W-1] ^ zi_q[mbt_pkg::Z_W-1]) ?
	                -$signed({{(mbt_pkg::Z_W - mbt_pkg::SQ_W){1'b0}}, ri_mag}) :
	                 $signed({{(mbt_pkg::Z_W - mbt_pkg::SQ_W){1'b0}}, ri_mag});

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbt_pkg::ENG_IDLE: begin
				if (q_valid) state_d = mbt_pkg::ENG_ADD;
			end
			mbt_pkg::ENG_ADD: begin
				if (!finish)       state_d = mbt_pkg::ENG_MUL;
				else if (out_free) state_d = mbt_pkg::ENG_IDLE;
			end
			mbt_pkg::ENG_MUL: begin
				state_d = mbt_pkg::ENG_ADD;
			end
			default: state_d = mbt_pkg::ENG_IDLE;
		endcase
	end

	always_comb begin
		load    = 1'b0;
		do_step = 1'b0;
		do_mul  = 1'b0;
		deliver = 1'b0;
		case (state_q)
			mbt_pkg::ENG_IDLE: load    = q_valid;
			mbt_pkg::ENG_ADD: begin
				do_step = !finish;
				deliver = finish && out_free;
			end
			mbt_pkg::ENG_MUL:  do_mul  = 1'b1;
			default: begin
				load = 1'b0;
			end
		endcase
	end

	assign q_pop     = load;
	assign out_valid = out_valid_q;
	assign in_set    = in_set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbt_pkg::ENG_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cr_q   <= q_data.cr;
			ci_q   <= q_data.ci;
			zr_q   <= '0;
			zi_q   <= '0;
			rr_q   <= '0;
			ii_q   <= '0;
			ri_q   <= '0;
			big_q  <= 1'b0;
			iter_q <= '0;
		end
		if (do_step) begin
			zr_q   <= zr_next;
			zi_q   <= zi_next;
			big_q  <= big_next;
			iter_q <= iter_q + mbt_pkg::ITER_W'(1);
		end
		if (do_mul) begin
			rr_q <= prr[mbt_pkg::FRAC_BITS +: mbt_pkg::SQ_W];
			ii_q <= pii[mbt_pkg::FRAC_BITS +: mbt_pkg::SQ_W];
			ri_q <= ri_val;
		end
		if (deliver) begin
			in_set_q <= !escaped;
		end
	end

endmodule

// ===== design/mandelbrot_membership_test.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_membership_test: Mandelbrot set membership by escape time
// Iterates z = z*z + c from z = 0 for each point c and reports whether the
// point stays bounded for the configured number of iterations.
// ----------------------------------------------------------------------------
// A request carries one point c as c_real and c_imag, signed Q3.28, on the
// in_valid / in_ready channel. Each request yields exactly one result, in_set,
// on the out_valid / out_ready channel, in request order. in_set is 1 when
// |z| stayed below 2 for max_iterations updates (also when that count is 0)
// and 0 as soon as an update reaches |z| >= 2.
// The max_iterations register is written through cfg_valid / cfg_ready; the
// port is always ready. It resets to 10000. The user must see that it is
// written only while idle; the block itself does not enforce this. Requests
// pass through an intake stage and a two-entry queue to the iteration
// engine. The engine takes one point at a time: it loads a point in its idle
// state, then runs an add state and a multiply state for each iteration;
// that loop sets the throughput.
// When the receiver stalls, the finished result waits in the output register
// while the engine starts the next point and the queue fills with requests.
// Reset empties the queue and the output register and restores the register.
// ----------------------------------------------------------------------------
module mandelbrot_membership_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] c_real,
	input  logic signed [31:0] c_imag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               in_set,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        max_iterations
);

	mbt_pkg::iter_t  max_iter_q;
	logic            push, q_full, q_pop, q_valid;
	mbt_pkg::point_t push_data, q_data;

	// The register write never has to wait.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= mbt_pkg::MAX_ITER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_iter_q <= max_iterations;
		end
	end

	// Intake converts each point to the internal format.
	mbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.c_real    (c_real),
		.c_imag    (c_imag),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Decouples intake from the long-running engine.
	mbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	// Iteration engine and output register.
	mbt_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_iterations (max_iter_q),
		.q_valid        (q_valid),
		.q_data         (q_data),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.in_set         (in_set)
	);

endmodule

// ===== tb/membership_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// membership_scoreboard_pkg: expected in_set values for the Mandelbrot test
// Holds an independent escape-time predictor with its own iteration limit and
// a queue of expected in_set bits, checked in request order.
// ----------------------------------------------------------------------------
package membership_scoreboard_pkg;

	class membership_scoreboard;

		mbt_pkg::iter_t iter_limit;
		bit             expected_in_set[$];
		int unsigned    points_noted;
		int unsigned    results_checked;
		int unsigned    inside_seen;
		int unsigned    failures;

		function new();
			iter_limit      = mbt_pkg::MAX_ITER_RESET;
			points_noted    = 0;
			results_checked = 0;
			inside_seen     = 0;
			failures        = 0;
		endfunction

		function void set_limit(input mbt_pkg::iter_t limit);
			iter_limit = limit;
		endfunction

		function int unsigned pending();
			return expected_in_set.size();
		endfunction

		// Product truncated toward zero to FRAC_BITS fraction bits.
		function longint trunc_mul(input longint a, input longint b);
			logic [127:0] ua;
			logic [127:0] ub;
			logic [127:0] p;
			bit           neg;
			neg = (a < 0) != (b < 0);
			ua  = (a < 0) ? 128'(-a) : 128'(a);
			ub  = (b < 0) ? 128'(-b) : 128'(b);
			p   = (ua * ub) >> mbt_pkg::FRAC_BITS;
			return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		endfunction

		// Runs z = z*z + c from zero and reports whether z never escaped.
		function bit stays_bounded(input logic signed [31:0] cr_raw,
				input logic signed [31:0] ci_raw);
			longint      cr;
			longint      ci;
			longint      zr;
			longint      zi;
			longint      rr;
			longint      ii;
			longint      ri;
			longint      two;
			longint      four;
			int unsigned n;
			cr   = (longint'(cr_raw) <<< mbt_pkg::UP_SHIFT) >>> mbt_pkg::DOWN_SHIFT;
			ci   = (longint'(ci_raw) <<< mbt_pkg::UP_SHIFT) >>> mbt_pkg::DOWN_SHIFT;
			two  = longint'(1) <<< (mbt_pkg::FRAC_BITS + 1);
			four = longint'(1) <<< (mbt_pkg::FRAC_BITS + 2);
			zr   = 0;
			zi   = 0;
			for (n = 0; n < iter_limit; n++) begin
				rr = trunc_mul(zr, zr);
				ii = trunc_mul(zi, zi);
				ri = trunc_mul(zr, zi);
				zr = rr - ii + cr;
				zi = 2 * ri + ci;
				if (zr >= two || zr <= -two || zi >= two || zi <= -two ||
						trunc_mul(zr, zr) + trunc_mul(zi, zi) >= four)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_point(input logic signed [31:0] cr_raw,
				input logic signed [31:0] ci_raw);
			expected_in_set = {expected_in_set, stays_bounded(cr_raw, ci_raw)};
			points_noted++;
		endfunction

		function void check_result(input logic got);
			bit want;
			if (expected_in_set.size() == 0) begin
				$error("in_set: result with no point pending, actual %0d", got);
				failures++;
				return;
			end
			want = expected_in_set.pop_front();
			results_checked++;
			if (want)
				inside_seen++;
			if (got !== want) begin
				$error("in_set mismatch: expected %0d, actual %0d", want, got);
				failures++;
			end
		endfunction

	endclass

endpackage

// ===== tb/mandelbrot_membership_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_membership_test_tb: self-checking bench for the membership test
// Drives points through the request channel under random bursts and
// backpressure, sweeps the iteration limit and checks every in_set result.
// ----------------------------------------------------------------------------
module mandelbrot_membership_test_tb;

	// The slowest correct run is dominated by the few inside points at the
	// large limits; this bound is several times that.
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	// Length of the long receiver hold-off used to fill the block up.
	localparam int HOLD_CYCLES = 300;

	// Handy Q3.28 values for the directed points.
	localparam logic signed [31:0] Q_ONE     = 32'sd1 <<< mbt_pkg::IN_FRAC;
	localparam logic signed [31:0] Q_TWO     = 32'sd2 <<< mbt_pkg::IN_FRAC;
	localparam logic signed [31:0] Q_HALF    = Q_ONE >>> 1;
	localparam logic signed [31:0] Q_QUARTER = Q_ONE >>> 2;
	localparam logic signed [31:0] Q_1P5     = Q_ONE + Q_HALF;
	localparam logic signed [31:0] Q_MAX     = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN     = 32'sh80000000;

	// Modes of the receiver's own stall pattern.
	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SLOW
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] c_real = '0;
	logic signed [31:0] c_imag = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               in_set;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_max_iterations = '0;

	membership_scoreboard_pkg::membership_scoreboard board;

	int unsigned cycles = 0;
	int          limits_written = 0;
	int          hold_asks = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          seg_left = 0;
	rx_mode_t    rx_mode = RX_FREE;

	mandelbrot_membership_test u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.c_real         (c_real),
		.c_imag         (c_imag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.in_set         (in_set),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_iterations (cfg_max_iterations)
	);

	always #6 clk = ~clk;

	// Watchdog: a run that never drains ends here as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results still expected",
				cycles, board.pending());
			$display("status: fail");
			$finish;
		end
	end

	// Receiver. It normally switches between segments of random length in
	// which it is always ready, ready on a coin flip, or ready with a chance of
	// one in four. When the stimulus asks for a hold-off, it drops ready for a long
	// stretch that it counts itself, so the block backs up into its input.
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_left <= $urandom_range(10, 80);
				rx_mode  <= rx_mode_t'($urandom_range(0, 2));
			end else begin
				seg_left <= seg_left - 1;
			end
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Every accepted result is compared against the oldest expectation.
	// Values are sampled at the edge, before any update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(in_set);
	end

	// Offers one point and returns at the edge that accepts it. Valid is
	// left high so that a following point goes out back to back.
	task automatic send_point(input logic signed [31:0] cr, input logic signed [31:0] ci);
		in_valid <= 1'b1;
		c_real   <= cr;
		c_imag   <= ci;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_point(cr, ci);
	endtask

	task automatic idle_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender stops and waits until every expected result has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// The limit register is only touched while the block is idle. Every
	// point yields a result, so an empty queue plus a short settle is enough.
	task automatic write_limit(input mbt_pkg::iter_t limit);
		wait_for_drain();
		repeat (8) @(posedge clk);
		cfg_valid          <= 1'b1;
		cfg_max_iterations <= limit;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_limit(limit);
		cfg_valid <= 1'b0;
		limits_written++;
	endtask

	function automatic logic signed [31:0] corner_coord();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return -32'sd1;
			4: return Q_TWO;
			default: return -Q_TWO;
		endcase
	endfunction

	// Random points in bursts of random length with random gaps. Most points
	// fall in the window around the set, where escape times vary the most;
	// the rest are arbitrary bit patterns and corner values.
	task automatic run_random_phase(input int n_points, input bit with_hold,
			input bit with_drain);
		int                 sent;
		int                 burst;
		int                 sel;
		logic signed [31:0] cr;
		logic signed [31:0] ci;
		sent = 0;
		if (with_hold)
			hold_asks <= hold_asks + 1;
		while (sent < n_points) begin
			// The first burst after a hold-off request runs without gaps so
			// that the input side stalls while the receiver holds off.
			burst = (with_hold && sent == 0) ? 14 : $urandom_range(1, 10);
			repeat (burst) begin
				if (sent < n_points) begin
					sel = $urandom_range(0, 9);
					if (sel < 6) begin
						cr = 32'($urandom_range(0, 671088640)) - 32'd536870912;
						ci = 32'($urandom_range(0, 671088640)) - 32'd335544320;
					end else if (sel < 9) begin
						cr = $urandom;
						ci = $urandom;
					end else begin
						cr = corner_coord();
						ci = corner_coord();
					end
					send_point(cr, ci);
					sent++;
					if (with_drain && sent == n_points / 2)
						wait_for_drain();
				end
			end
			if ($urandom_range(0, 2) != 0)
				idle_sender($urandom_range(1, 12));
		end
	endtask

	initial begin
		mbt_pkg::iter_t limit_plan[5];
		int             p;
		board = new();
		limit_plan[0] = mbt_pkg::iter_t'(24);
		limit_plan[1] = mbt_pkg::iter_t'(2);
		limit_plan[2] = mbt_pkg::iter_t'($urandom_range(5, 64));
		limit_plan[3] = mbt_pkg::iter_t'(64);
		limit_plan[4] = mbt_pkg::iter_t'($urandom_range(1, 16));

		// Reset once, asserted from time zero.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset limit: points that stay inside (origin, the orbit at -1
		// that alternates between 0 and -1, the orbit through i, a tiny point),
		// the extreme codes that escape on the first update, the exact |z| = 2 points
		// on both axes, and points whose components are below 2 while |z|^2 is not.
		send_point('0, '0);
		send_point(-Q_ONE, '0);
		send_point('0, Q_ONE);
		send_point(32'sd1, -32'sd1);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MIN, Q_MIN);
		send_point(Q_MAX, Q_MIN);
		send_point(Q_MIN, Q_MAX);
		send_point(-Q_TWO, '0);
		send_point(Q_TWO, '0);
		send_point('0, Q_TWO);
		send_point('0, -Q_TWO);
		send_point(Q_1P5, Q_1P5);
		send_point(-Q_1P5, -Q_1P5);

		// A limit of zero makes every point inside, even the extremes.
		write_limit('0);
		send_point(Q_MIN, Q_MAX);
		send_point(Q_1P5, Q_1P5);
		send_point('0, '0);

		// A single update: only points whose first z escapes are outside.
		write_limit(mbt_pkg::iter_t'(1));
		send_point(Q_1P5, Q_1P5);
		send_point(Q_ONE, Q_ONE);
		send_point(Q_QUARTER, '0);

		// The largest limit: one full-length inside point, the rest escape,
		// one of them only after a slow drift past the cusp.
		write_limit('1);
		send_point('0, '0);
		send_point(Q_HALF, '0);
		send_point(32'sd80530637, '0);
		send_point(Q_MAX, '0);

		for (p = 0; p < 5; p++) begin
			write_limit(limit_plan[p]);
			run_random_phase(16, p == 1, p == 3);
		end

		wait_for_drain();
		repeat (40) @(posedge clk);

		$display("Checked %0d of %0d points (%0d inside) over %0d limit writes, 0 to 65535.",
			board.results_checked, board.points_noted, board.inside_seen, limits_written);
		$display("Traffic had random bursts, stall patterns and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
